// ===== sv/magnetometer_calibration_core_assert.svh =====
// Assertion macros used by the magnetometer calibration core
`ifndef MAGNETOMETER_CALIBRATION_CORE_ASSERT_SVH
`define MAGNETOMETER_CALIBRATION_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define MCAL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define MCAL_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/mcal_pkg.sv =====
// Types and constants of the magnetometer calibration datapath
package mcal_pkg;

	typedef logic signed [15:0] coef_t;
	typedef logic signed [16:0] cnt_t;
	typedef logic signed [17:0] diff_t;
	typedef logic signed [33:0] prod_t;
	typedef logic signed [19:0] field_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

	localparam int NUM_AXES = 3;

	localparam logic [2:0] REG_OFFSET_X    = 3'd0;
	localparam logic [2:0] REG_OFFSET_Y    = 3'd1;
	localparam logic [2:0] REG_OFFSET_Z    = 3'd2;
	localparam logic [2:0] REG_GAIN_XX     = 3'd3;
	localparam logic [2:0] REG_GAIN_YY     = 3'd4;
	localparam logic [2:0] REG_GAIN_ZZ     = 3'd5;
	localparam logic [2:0] REG_CROSS_TERMS = 3'd6;

	localparam coef_t       RST_OFFSET_X    = -16'sd283;
	localparam coef_t       RST_OFFSET_Y    = -16'sd164;
	localparam coef_t       RST_OFFSET_Z    = 16'sd882;
	localparam coef_t       RST_GAIN_XX     = 16'sd16449;
	localparam coef_t       RST_GAIN_YY     = 16'sd16498;
	localparam coef_t       RST_GAIN_ZZ     = 16'sd16230;
	localparam logic [47:0] RST_CROSS_TERMS = 48'd2602740875261;

	// count * 12 + 2, biased to stay non-negative before the divide by five
	localparam logic signed [20:0] SCALE_BIAS  = 21'sd393222;
	// ceil(2^22 / 5): exact floor division by five for the biased range
	localparam logic [19:0]        SCALE_RECIP = 20'd838861;
	localparam int                 RECIP_SHIFT = 22;
	localparam logic signed [18:0] SCALE_UNBIAS = 19'sd78644;

	localparam logic signed [35:0] ROUND_HALF = 36'sd8192;
	localparam field_t             FIELD_MAX  = 20'sd524287;
	localparam field_t             FIELD_MIN  = -20'sd524288;

endpackage

// ===== sv/mcal_lane.sv =====
// One axis lane: scale the count, remove hard iron, multiply by its matrix row
module mcal_lane
	import mcal_pkg::*;
(
	input  logic      clk,
	input  stage_en_t en,
	input  cnt_t      count,
	input  coef_t     offset,
	input  coef_t     gain [NUM_AXES],
	output prod_t     prod [NUM_AXES]
);

	logic        [19:0] n_s1;
	logic        [17:0] q_s2;
	diff_t              d_s3;
	prod_t              prod_s4 [NUM_AXES];

	logic signed [20:0] n_full;
	logic        [39:0] q_full;
	logic signed [18:0] d_full;

	assign n_full = (21'(count) <<< 3) + (21'(count) <<< 2) + SCALE_BIAS;
	assign q_full = 40'(n_s1) * 40'(SCALE_RECIP);
	assign d_full = $signed({1'b0, q_s2}) - SCALE_UNBIAS - 19'(offset);

	always_ff @(posedge clk) begin
		if (en.s1) begin
			n_s1 <= n_full[19:0];
		end
		if (en.s2) begin
			q_s2 <= q_full[RECIP_SHIFT+17:RECIP_SHIFT];
		end
		if (en.s3) begin
			d_s3 <= d_full[17:0];
		end
		if (en.s4) begin
			for (int k = 0; k < NUM_AXES; k++) begin
				prod_s4[k] <= 34'(d_s3) * 34'(gain[k]);
			end
		end
	end

	assign prod = prod_s4;

endmodule

// ===== sv/mcal_merge.sv =====
// Merge stage: sum lane products per axis, round, saturate, flag clipping
module mcal_merge
	import mcal_pkg::*;
(
	input  logic      clk,
	input  stage_en_t en,
	input  prod_t     prod [NUM_AXES][NUM_AXES],
	output field_t    field [NUM_AXES],
	output logic      clipped
);

	field_t             field_q [NUM_AXES];
	logic               clipped_q;
	field_t             sat [NUM_AXES];
	logic [NUM_AXES-1:0] clip_ax;
	logic signed [35:0] acc [NUM_AXES];
	logic signed [21:0] rnd [NUM_AXES];

	always_comb begin
		for (int k = 0; k < NUM_AXES; k++) begin
			acc[k] = 36'(prod[0][k]) + 36'(prod[1][k]) + 36'(prod[2][k]) + ROUND_HALF;
			rnd[k] = $signed(acc[k][35:14]);
			if (rnd[k] > 22'(FIELD_MAX)) begin
				sat[k]     = FIELD_MAX;
				clip_ax[k] = 1'b1;
			end else if (rnd[k] < 22'(FIELD_MIN)) begin
				sat[k]     = FIELD_MIN;
				clip_ax[k] = 1'b1;
			end else begin
				sat[k]     = rnd[k][19:0];
				clip_ax[k] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			field_q   <= sat;
			clipped_q <= |clip_ax;
		end
	end

	assign field   = field_q;
	assign clipped = clipped_q;

endmodule

// ===== sv/magnetometer_calibration_core.sv =====
// Magnetometer hard/soft-iron calibration core: one word per clock cycle while
// the output side does not stall. Three axis lanes each run a 20x20
// reciprocal multiply and an 18x16 row multiply, registered; the merge stage
// sums, rounds and saturates into the output register. Each stage holds its
// word on its own, so input words are taken while a result waits at the
// output. The user must write registers only while no word is in flight;
// the block itself does not enforce this.
`include "magnetometer_calibration_core_assert.svh"

module magnetometer_calibration_core
	import mcal_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          x_low,
	input  logic [7:0]          x_high,
	input  logic [7:0]          y_low,
	input  logic [7:0]          y_high,
	input  logic [7:0]          z_low,
	input  logic [7:0]          z_high,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [19:0]  field_x,
	output logic signed [19:0]  field_y,
	output logic signed [19:0]  field_z,
	output logic                clipped,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [47:0]         cfg_data
);

	coef_t       offset_q [NUM_AXES];
	coef_t       diag_q [NUM_AXES];
	logic [47:0] cross_q;

	logic v_s1, v_s2, v_s3, v_s4, out_valid_q;
	stage_en_t en;

	cnt_t   count [NUM_AXES];
	coef_t  gain_row [NUM_AXES][NUM_AXES];
	prod_t  lane_prod [NUM_AXES][NUM_AXES];
	field_t field [NUM_AXES];

	logic       in_acc;
	logic       out_acc;
	logic [2:0] occ;

	// write configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q[0] <= RST_OFFSET_X;
			offset_q[1] <= RST_OFFSET_Y;
			offset_q[2] <= RST_OFFSET_Z;
			diag_q[0]   <= RST_GAIN_XX;
			diag_q[1]   <= RST_GAIN_YY;
			diag_q[2]   <= RST_GAIN_ZZ;
			cross_q     <= RST_CROSS_TERMS;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OFFSET_X:    offset_q[0] <= cfg_data[15:0];
				REG_OFFSET_Y:    offset_q[1] <= cfg_data[15:0];
				REG_OFFSET_Z:    offset_q[2] <= cfg_data[15:0];
				REG_GAIN_XX:     diag_q[0]   <= cfg_data[15:0];
				REG_GAIN_YY:     diag_q[1]   <= cfg_data[15:0];
				REG_GAIN_ZZ:     diag_q[2]   <= cfg_data[15:0];
				REG_CROSS_TERMS: cross_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// symmetric matrix rows
	always_comb begin
		gain_row[0][0] = diag_q[0];
		gain_row[0][1] = cross_q[15:0];
		gain_row[0][2] = cross_q[31:16];
		gain_row[1][0] = cross_q[15:0];
		gain_row[1][1] = diag_q[1];
		gain_row[1][2] = cross_q[47:32];
		gain_row[2][0] = cross_q[31:16];
		gain_row[2][1] = cross_q[47:32];
		gain_row[2][2] = diag_q[2];
	end

	// assemble counts, negate Y into the body frame
	assign count[0] = 17'($signed({x_high, x_low}));
	assign count[1] = -17'($signed({y_high, y_low}));
	assign count[2] = 17'($signed({z_high, z_low}));

	// advance a stage when it is empty or its word moves on
	assign en.s5 = !out_valid_q || out_ready;
	assign en.s4 = !v_s4 || en.s5;
	assign en.s3 = !v_s3 || en.s4;
	assign en.s2 = !v_s2 || en.s3;
	assign en.s1 = !v_s1 || en.s2;

	assign in_ready = en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en.s1) begin
				v_s1 <= in_valid;
			end
			if (en.s2) begin
				v_s2 <= v_s1;
			end
			if (en.s3) begin
				v_s3 <= v_s2;
			end
			if (en.s4) begin
				v_s4 <= v_s3;
			end
			if (en.s5) begin
				out_valid_q <= v_s4;
			end
		end
	end

	for (genvar j = 0; j < NUM_AXES; j++) begin : g_lane
		mcal_lane u_lane (
			.clk    (clk),
			.en     (en),
			.count  (count[j]),
			.offset (offset_q[j]),
			.gain   (gain_row[j]),
			.prod   (lane_prod[j])
		);
	end

	mcal_merge u_merge (
		.clk     (clk),
		.en      (en),
		.prod    (lane_prod),
		.field   (field),
		.clipped (clipped)
	);

	assign out_valid = out_valid_q;
	assign field_x   = field[0];
	assign field_y   = field[1];
	assign field_z   = field[2];

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid_q && out_ready;
	assign occ     = 3'(v_s1) + 3'(v_s2) + 3'(v_s3) + 3'(v_s4) + 3'(out_valid_q);

	`MCAL_ASSERT_NXT(a_occ_tracks, arst_n, occ == $past(occ) + 3'($past(in_acc)) - 3'($past(out_acc)), "pipeline occupancy lost or gained a word")
	`MCAL_ASSERT_IMP(a_stall_full, !in_ready, v_s1 && v_s2 && v_s3 && v_s4 && out_valid_q && !out_ready, "input stalled with a free stage")
	`MCAL_ASSERT_IMP(a_clip_rail, out_valid_q && clipped, field_x == FIELD_MAX || field_x == FIELD_MIN || field_y == FIELD_MAX || field_y == FIELD_MIN || field_z == FIELD_MAX || field_z == FIELD_MIN, "clip flag without a saturated axis")

endmodule
